[hw/rtl/grid_neighbour_from_direction_unit_defines.svh]
// Assertion macros shared by the grid neighbour checker.
`ifndef GRID_NEIGHBOUR_FROM_DIRECTION_UNIT_DEFINES_SVH
`define GRID_NEIGHBOUR_FROM_DIRECTION_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define GND_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GND_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/gnd_pkg.sv]
// Shared constants, types and helper functions of the grid neighbour unit.
`default_nettype none
package gnd_pkg;

    localparam int NODE_W     = 16;
    localparam int IN_DIR_W   = 8;
    localparam int EDGE_W     = 9;
    localparam int MAX_EDGE   = 256;
    localparam int RESET_EDGE = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = EDGE_W;

    localparam int ESAT_W     = $clog2(MAX_EDGE + 1);
    localparam int COORD_W    = $clog2(MAX_EDGE);
    localparam int DIV_W      = ESAT_W + COORD_W;
    localparam int COUNT_W    = 2 * ESAT_W;

    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (COORD_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    localparam int IN_TDATA_W  = ((NODE_W + IN_DIR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NODE_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_EDGE = 1'd1;

    localparam logic MODE_HEX    = 1'b0;
    localparam logic MODE_SQUARE = 1'b1;

    // Hexagon direction codes
    localparam logic [2:0] HEX_NW = 3'd0;
    localparam logic [2:0] HEX_W  = 3'd1;
    localparam logic [2:0] HEX_SW = 3'd2;
    localparam logic [2:0] HEX_SE = 3'd3;
    localparam logic [2:0] HEX_E  = 3'd4;
    localparam logic [2:0] HEX_NE = 3'd5;

    // Square direction codes
    localparam logic [2:0] SQ_N = 3'd0;
    localparam logic [2:0] SQ_W = 3'd1;
    localparam logic [2:0] SQ_S = 3'd2;
    localparam logic [2:0] SQ_E = 3'd3;

    typedef struct packed {
        logic       oor;
        logic [2:0] dmod;
    } t_side;

    typedef struct packed {
        logic [NODE_W-1:0]  rem;
        logic [COORD_W-1:0] quot;
    } t_div;

    // Direction modulo 6 by reciprocal multiply; exact for 8-bit inputs.
    function automatic logic [2:0] mod6(input logic [IN_DIR_W-1:0] d);
        logic [IN_DIR_W+7:0] p;
        logic [IN_DIR_W-1:0] q;
        logic [IN_DIR_W-1:0] r;
        p = (IN_DIR_W + 8)'(d) * (IN_DIR_W + 8)'(171);
        q = IN_DIR_W'(p >> 10);
        r = d - IN_DIR_W'(q * IN_DIR_W'(6));
        return r[2:0];
    endfunction

    // One restoring division step producing quotient bit k.
    function automatic t_div div_step(input t_div a, input logic [ESAT_W-1:0] esat,
                                      input int k);
        logic [DIV_W-1:0] trial;
        t_div             res;
        res   = a;
        trial = DIV_W'(esat) << k;
        if (DIV_W'(a.rem) >= trial) begin
            res.rem     = a.rem - NODE_W'(trial);
            res.quot[k] = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [ESAT_W-1:0] sat_edge(input logic [EDGE_W-1:0] v);
        if (32'(v) > MAX_EDGE) begin
            return ESAT_W'(MAX_EDGE);
        end
        return ESAT_W'(v);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/grid_neighbour_from_direction_unit.sv]
// Top level of the grid neighbour unit: node index and direction in, neighbour index out.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------------------
//  s        | in        | i_s_tvalid / o_s_tready   | i_s_tdata: current_node, direction
//  m        | out       | o_m_tvalid / i_m_tready   | o_m_tdata: neighbour_node,
//           |           |                           | o_m_tuser: node_out_of_range
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle is accepted while the output is not stalled; a result passes
// through seven register stages (input register, 4 divider stages at 2 quotient bits each,
// neighbour select, output).
// The restoring divider that splits the node index into row and column sets the depth.
// Reset restores grid_mode = square and grid_edge = 16 and empties the pipeline.
// When the output holds a result that is not taken, every stage holds.
`default_nettype none
module grid_neighbour_from_direction_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [gnd_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // [15:0] current_node, [23:16] direction
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [gnd_pkg::OUT_TDATA_W-1:0]          o_m_tdata,   // [15:0] neighbour_node
    output logic [0:0]                               o_m_tuser,   // [0] node_out_of_range
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gnd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gnd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration
    logic                           r_mode;
    logic [gnd_pkg::ESAT_W-1:0]     r_esat;
    logic [gnd_pkg::COUNT_W-1:0]    r_count;
    logic [gnd_pkg::ESAT_W-1:0]     n_esat;

    assign o_cfg_ready = 1'b1;
    assign n_esat      = gnd_pkg::sat_edge(i_cfg_data[gnd_pkg::EDGE_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= gnd_pkg::MODE_SQUARE;
            r_esat  <= gnd_pkg::ESAT_W'(gnd_pkg::RESET_EDGE);
            r_count <= gnd_pkg::COUNT_W'(gnd_pkg::RESET_EDGE * gnd_pkg::RESET_EDGE);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gnd_pkg::CFG_GRID_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                gnd_pkg::CFG_GRID_EDGE: begin
                    r_esat  <= n_esat;
                    r_count <= gnd_pkg::COUNT_W'(n_esat) * gnd_pkg::COUNT_W'(n_esat);
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline advance: everything moves unless a result waits at the output.
    logic en;
    logic r_m_valid;

    assign en         = !r_m_valid || i_m_tready;
    assign o_s_tready = en;

    // Stage A: input register
    logic [gnd_pkg::NODE_W-1:0]     in_node;
    logic [gnd_pkg::IN_DIR_W-1:0]   in_dir;
    gnd_pkg::t_side                 n_a_side;
    logic                           r_a_valid;
    logic [gnd_pkg::NODE_W-1:0]     r_a_node;
    gnd_pkg::t_side                 r_a_side;

    assign in_node = i_s_tdata[gnd_pkg::NODE_W-1:0];
    assign in_dir  = i_s_tdata[gnd_pkg::NODE_W +: gnd_pkg::IN_DIR_W];

    always_comb begin
        n_a_side.oor  = gnd_pkg::COUNT_W'(in_node) >= r_count;
        n_a_side.dmod = (r_mode == gnd_pkg::MODE_SQUARE) ? {1'b0, in_dir[1:0]}
                                                         : gnd_pkg::mod6(in_dir);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_node <= in_node;
            r_a_side <= n_a_side;
        end
    end

    // Stages B..E: row and column
    logic                           div_valid;
    gnd_pkg::t_side                 div_side;
    logic [gnd_pkg::COORD_W-1:0]    div_quot;
    logic [gnd_pkg::NODE_W-1:0]     div_rem;

    gnd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_valid),
        .i_side  (r_a_side),
        .i_node  (r_a_node),
        .i_esat  (r_esat),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // Stage F: check all candidate directions, take the first on the grid
    logic [gnd_pkg::COORD_W-1:0]    x;
    logic [gnd_pkg::COORD_W-1:0]    y;
    logic                           odd;
    logic                           x_lo;
    logic                           x_hi;
    logic                           y_lo;
    logic                           y_hi;
    logic [5:0]                     cand_ok;
    logic [3:0]                     ndir;
    logic                           found;
    logic [2:0]                     pick;
    logic                           inc_x;
    logic                           dec_x;
    logic                           inc_y;
    logic                           dec_y;
    logic [gnd_pkg::COORD_W-1:0]    n_nx;
    logic [gnd_pkg::COORD_W-1:0]    n_ny;

    assign x    = div_rem[gnd_pkg::COORD_W-1:0];
    assign y    = div_quot;
    assign odd  = y[0];
    assign x_lo = x != '0;
    assign y_lo = y != '0;
    assign x_hi = (gnd_pkg::ESAT_W'(x) + gnd_pkg::ESAT_W'(1)) < r_esat;
    assign y_hi = (gnd_pkg::ESAT_W'(y) + gnd_pkg::ESAT_W'(1)) < r_esat;

    always_comb begin
        if (r_mode == gnd_pkg::MODE_SQUARE) begin
            cand_ok = {2'b00, x_hi, y_hi, x_lo, y_lo};
            ndir    = 4'd4;
        end else begin
            cand_ok[gnd_pkg::HEX_NW] = y_lo && (odd || x_lo);
            cand_ok[gnd_pkg::HEX_W]  = x_lo;
            cand_ok[gnd_pkg::HEX_SW] = y_hi && (odd || x_lo);
            cand_ok[gnd_pkg::HEX_SE] = y_hi && (!odd || x_hi);
            cand_ok[gnd_pkg::HEX_E]  = x_hi;
            cand_ok[gnd_pkg::HEX_NE] = y_lo && (!odd || x_hi);
            ndir                     = 4'd6;
        end
    end

    // Walk counterclockwise from the requested direction.
    always_comb begin
        logic [3:0] idx;
        found = 1'b0;
        pick  = div_side.dmod;
        for (int t = 0; t < 6; t++) begin
            idx = {1'b0, div_side.dmod} + 4'(t);
            if (idx >= ndir) begin
                idx = idx - ndir;
            end
            if (!found && (4'(t) < ndir) && cand_ok[idx[2:0]]) begin
                found = 1'b1;
                pick  = idx[2:0];
            end
        end
    end

    always_comb begin
        inc_x = 1'b0;
        dec_x = 1'b0;
        inc_y = 1'b0;
        dec_y = 1'b0;
        if (r_mode == gnd_pkg::MODE_SQUARE) begin
            unique case (pick)
                gnd_pkg::SQ_N: dec_y = 1'b1;
                gnd_pkg::SQ_W: dec_x = 1'b1;
                gnd_pkg::SQ_S: inc_y = 1'b1;
                gnd_pkg::SQ_E: inc_x = 1'b1;
                default: begin
                end
            endcase
        end else begin
            unique case (pick)
                gnd_pkg::HEX_NW: begin
                    dec_y = 1'b1;
                    dec_x = !odd;
                end
                gnd_pkg::HEX_W:  dec_x = 1'b1;
                gnd_pkg::HEX_SW: begin
                    inc_y = 1'b1;
                    dec_x = !odd;
                end
                gnd_pkg::HEX_SE: begin
                    inc_y = 1'b1;
                    inc_x = odd;
                end
                gnd_pkg::HEX_E:  inc_x = 1'b1;
                gnd_pkg::HEX_NE: begin
                    dec_y = 1'b1;
                    inc_x = odd;
                end
                default: begin
                end
            endcase
        end
        // Nothing on the grid (edge of one): stay on the node itself.
        if (!found) begin
            inc_x = 1'b0;
            dec_x = 1'b0;
            inc_y = 1'b0;
            dec_y = 1'b0;
        end
        n_nx = x + gnd_pkg::COORD_W'(inc_x) - gnd_pkg::COORD_W'(dec_x);
        n_ny = y + gnd_pkg::COORD_W'(inc_y) - gnd_pkg::COORD_W'(dec_y);
    end

    logic                           r_f_valid;
    logic                           r_f_oor;
    logic [gnd_pkg::COORD_W-1:0]    r_f_nx;
    logic [gnd_pkg::COORD_W-1:0]    r_f_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_oor <= div_side.oor;
            r_f_nx  <= n_nx;
            r_f_ny  <= n_ny;
        end
    end

    // Stage G: linear index row * edge + column into the output register
    logic [gnd_pkg::COUNT_W-1:0]    lin;
    logic [gnd_pkg::NODE_W-1:0]     n_m_data;
    logic [gnd_pkg::NODE_W-1:0]     r_m_data;
    logic                           r_m_oor;

    assign lin      = gnd_pkg::COUNT_W'(r_f_ny) * gnd_pkg::COUNT_W'(r_esat)
                    + gnd_pkg::COUNT_W'(r_f_nx);
    assign n_m_data = r_f_oor ? '0 : lin[gnd_pkg::NODE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_data <= n_m_data;
            r_m_oor  <= r_f_oor;
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = gnd_pkg::OUT_TDATA_W'(r_m_data);
    assign o_m_tuser[0] = r_m_oor;

endmodule
`default_nettype wire

[hw/rtl/gnd_divider.sv]
// Pipelined restoring divider: node index into row (quotient) and column (remainder).
`default_nettype none
module gnd_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire gnd_pkg::t_side                i_side,
    input  wire logic [gnd_pkg::NODE_W-1:0]    i_node,
    input  wire logic [gnd_pkg::ESAT_W-1:0]    i_esat,
    output logic                               o_valid,
    output gnd_pkg::t_side                     o_side,
    output logic [gnd_pkg::COORD_W-1:0]        o_quot,
    output logic [gnd_pkg::NODE_W-1:0]         o_rem
);

    logic            r_valid [gnd_pkg::DIV_STAGES];
    gnd_pkg::t_side  r_side  [gnd_pkg::DIV_STAGES];
    gnd_pkg::t_div   r_div   [gnd_pkg::DIV_STAGES];
    gnd_pkg::t_div   d_in    [gnd_pkg::DIV_STAGES];
    gnd_pkg::t_div   n_div   [gnd_pkg::DIV_STAGES];

    always_comb begin
        d_in[0].rem  = i_node;
        d_in[0].quot = '0;
        for (int s = 1; s < gnd_pkg::DIV_STAGES; s++) begin
            d_in[s] = r_div[s-1];
        end
    end

    // Each stage resolves STEPS_PER_STAGE quotient bits, most significant first.
    always_comb begin
        gnd_pkg::t_div t;
        int            k;
        for (int s = 0; s < gnd_pkg::DIV_STAGES; s++) begin
            t = d_in[s];
            for (int j = 0; j < gnd_pkg::STEPS_PER_STAGE; j++) begin
                k = gnd_pkg::COORD_W - 1 - s * gnd_pkg::STEPS_PER_STAGE - j;
                if (k >= 0) begin
                    t = gnd_pkg::div_step(t, i_esat, k);
                end
            end
            n_div[s] = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < gnd_pkg::DIV_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < gnd_pkg::DIV_STAGES; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < gnd_pkg::DIV_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int s = 0; s < gnd_pkg::DIV_STAGES; s++) begin
                r_div[s] <= n_div[s];
            end
        end
    end

    assign o_valid = r_valid[gnd_pkg::DIV_STAGES-1];
    assign o_side  = r_side[gnd_pkg::DIV_STAGES-1];
    assign o_quot  = r_div[gnd_pkg::DIV_STAGES-1].quot;
    assign o_rem   = r_div[gnd_pkg::DIV_STAGES-1].rem;

endmodule
`default_nettype wire

[hw/rtl/gnd_checker.sv]
// Port-level checker for the grid neighbour unit, bound to the top level.
`default_nettype none
`include "grid_neighbour_from_direction_unit_defines.svh"
module gnd_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                o_s_tready,
    input  wire logic                                o_m_tvalid,
    input  wire logic                                i_m_tready,
    input  wire logic [gnd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  wire logic [0:0]                          o_m_tuser
);

    `GND_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
    `GND_ASSERT(a_oor_zero, o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0, "flagged node gave nonzero neighbour")
    `GND_ASSERT(a_ready_rule, o_s_tready == (!o_m_tvalid || i_m_tready), "input ready does not follow output stall")
    `GND_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")

endmodule

bind grid_neighbour_from_direction_unit gnd_checker u_gnd_checker (.*);
`default_nettype wire

[bench/grid_neighbour_from_direction_unit_tb.sv]
// Self-checking bench for the grid neighbour unit: random and corner lookups under stream stalls.
`timescale 1ns / 1ps
module grid_neighbour_from_direction_unit_tb;

    localparam int PIPE_LATENCY = 7;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [gnd_pkg::NODE_W-1:0]   node;
        logic [gnd_pkg::IN_DIR_W-1:0] dir;
    } t_lookup;

    typedef struct packed {
        logic [gnd_pkg::NODE_W-1:0] neighbour;
        logic                       oor;
    } t_neighbour;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [gnd_pkg::IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [gnd_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [0:0]                      o_m_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [gnd_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [gnd_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Bench copy of the configuration registers, reset values
    logic                        model_mode = gnd_pkg::MODE_SQUARE;
    logic [gnd_pkg::EDGE_W-1:0]  model_edge = gnd_pkg::EDGE_W'(gnd_pkg::RESET_EDGE);

    t_lookup    pending_lookups[$];
    t_neighbour expected_neighbours[$];
    int         mismatch_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    logic       ready_hold = 1'b0;

    grid_neighbour_from_direction_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int active_edge();
        return (int'(model_edge) > gnd_pkg::MAX_EDGE) ? gnd_pkg::MAX_EDGE : int'(model_edge);
    endfunction

    function automatic t_neighbour predict_neighbour(
            input logic [gnd_pkg::NODE_W-1:0]   node,
            input logic [gnd_pkg::IN_DIR_W-1:0] dir);
        t_neighbour res;
        int         e;
        int         x;
        int         y;
        int         nx;
        int         ny;
        int         d;
        int         ndir;
        int         tries;
        logic       odd;
        logic       hit;
        logic [2:0] code;
        e = active_edge();
        res = '0;
        if (e == 0 || int'(node) >= e * e) begin
            res.oor = 1'b1;
            return res;
        end
        if (e == 1) begin
            res.neighbour = node;
            return res;
        end
        x = int'(node) % e;
        y = int'(node) / e;
        nx = x;
        ny = y;
        odd = y[0];
        ndir = (model_mode == gnd_pkg::MODE_SQUARE) ? 4 : 6;
        d = int'(dir) % ndir;
        hit = 1'b0;
        // Rotate to the next direction until the neighbour lands on the grid
        for (tries = 0; tries < ndir && !hit; tries++) begin
            code = 3'(d);
            if (model_mode == gnd_pkg::MODE_SQUARE) begin
                case (code)
                    gnd_pkg::SQ_N: begin nx = x;     ny = y - 1; end
                    gnd_pkg::SQ_W: begin nx = x - 1; ny = y;     end
                    gnd_pkg::SQ_S: begin nx = x;     ny = y + 1; end
                    default: begin nx = x + 1; ny = y;  end
                endcase
            end else begin
                case (code)
                    gnd_pkg::HEX_NW: begin nx = odd ? x : x - 1;  ny = y - 1; end
                    gnd_pkg::HEX_W:  begin nx = x - 1;            ny = y;     end
                    gnd_pkg::HEX_SW: begin nx = odd ? x : x - 1;  ny = y + 1; end
                    gnd_pkg::HEX_SE: begin nx = odd ? x + 1 : x;  ny = y + 1; end
                    gnd_pkg::HEX_E:  begin nx = x + 1;            ny = y;     end
                    default: begin nx = odd ? x + 1 : x; ny = y - 1; end
                endcase
            end
            if (nx >= 0 && ny >= 0 && nx < e && ny < e) begin
                hit = 1'b1;
            end else begin
                d = (d + 1) % ndir;
            end
        end
        res.neighbour = gnd_pkg::NODE_W'(ny * e + nx);
        return res;
    endfunction

    // Bias toward the border so the fallback search gets exercised
    function automatic int pick_coord(input int e);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return e - 1;
            default: return int'($urandom_range(0, e - 1));
        endcase
    endfunction

    function automatic t_lookup random_lookup();
        t_lookup item;
        int      e;
        int      cells;
        int      kind;
        e = active_edge();
        cells = e * e;
        kind = $urandom_range(0, 9);
        item.dir = gnd_pkg::IN_DIR_W'($urandom_range(0, 255));
        if (kind == 0 || e == 0) begin
            item.node = gnd_pkg::NODE_W'($urandom_range(0, 65535));
        end else if (kind == 1 && cells < 65536) begin
            item.node = gnd_pkg::NODE_W'($urandom_range(cells, 65535));
        end else begin
            item.node = gnd_pkg::NODE_W'(pick_coord(e) * e + pick_coord(e));
        end
        return item;
    endfunction

    task automatic push_lookup(input int node, input int dir);
        t_lookup item;
        item.node = gnd_pkg::NODE_W'(node);
        item.dir  = gnd_pkg::IN_DIR_W'(dir);
        pending_lookups.push_back(item);
    endtask

    task automatic push_random(input int count);
        repeat (count) pending_lookups.push_back(random_lookup());
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic set_traffic(input int send_idle, input int stall);
        send_idle_pct = send_idle;
        stall_pct = stall;
    endtask

    // Hold until every lookup went in and every result came out, then let the pipe settle
    task automatic wait_drained();
        while (pending_lookups.size() != 0 || i_s_tvalid || expected_neighbours.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [gnd_pkg::CFG_IDX_W-1:0]  idx,
                                  input logic [gnd_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == gnd_pkg::CFG_GRID_MODE) begin
            model_mode = value[0];
        end else begin
            model_edge = gnd_pkg::EDGE_W'(value);
        end
    endtask

    task automatic configure_grid(input logic mode, input int edge_len);
        write_register(gnd_pkg::CFG_GRID_MODE, gnd_pkg::CFG_DATA_W'(mode));
        write_register(gnd_pkg::CFG_GRID_EDGE, gnd_pkg::CFG_DATA_W'(edge_len));
    endtask

    // Driver: record the expectation on each accepted transaction, then offer the next lookup
    always @(posedge i_clk) begin : drive_lookups
        t_lookup nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_neighbours.push_back(
                    predict_neighbour(i_s_tdata[gnd_pkg::NODE_W-1:0],
                                      i_s_tdata[gnd_pkg::NODE_W +: gnd_pkg::IN_DIR_W]));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_lookups.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_lookups.pop_front();
                    i_s_tdata  <= gnd_pkg::IN_TDATA_W'({nxt.dir, nxt.node});
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_neighbour want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_neighbours.size() == 0) begin
                    report_mismatch($sformatf("unexpected result node %0d flag %0d",
                                              o_m_tdata[gnd_pkg::NODE_W-1:0], o_m_tuser[0]));
                end else begin
                    want = expected_neighbours.pop_front();
                    if (o_m_tdata[gnd_pkg::NODE_W-1:0] !== want.neighbour) begin
                        report_mismatch($sformatf("neighbour_node got %0d want %0d",
                                                  o_m_tdata[gnd_pkg::NODE_W-1:0],
                                                  want.neighbour));
                    end
                    if (o_m_tuser[0] !== want.oor) begin
                        report_mismatch($sformatf("node_out_of_range got %0d want %0d",
                                                  o_m_tuser[0], want.oor));
                    end
                end
            end
            i_m_tready <= !ready_hold && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Square grid of 16 at reset: corners, borders, interior, off-grid nodes
        set_traffic(0, 0);
        push_lookup(0, gnd_pkg::SQ_N);
        push_lookup(0, gnd_pkg::SQ_W);
        push_lookup(15, gnd_pkg::SQ_N);
        push_lookup(15, gnd_pkg::SQ_E);
        push_lookup(240, gnd_pkg::SQ_S);
        push_lookup(255, gnd_pkg::SQ_S);
        push_lookup(255, gnd_pkg::SQ_E);
        push_lookup(255, 255);
        push_lookup(17, gnd_pkg::SQ_N);
        push_lookup(17, gnd_pkg::SQ_W);
        push_lookup(17, gnd_pkg::SQ_S);
        push_lookup(17, gnd_pkg::SQ_E);
        push_lookup(256, gnd_pkg::SQ_N);
        push_lookup(65535, 255);
        wait_drained();

        // Offset rows: even and odd row borders
        configure_grid(gnd_pkg::MODE_HEX, 16);
        push_lookup(0, gnd_pkg::HEX_NW);
        push_lookup(16, gnd_pkg::HEX_NW);
        push_lookup(16, gnd_pkg::HEX_W);
        push_lookup(31, gnd_pkg::HEX_E);
        push_lookup(240, gnd_pkg::HEX_SW);
        push_lookup(255, gnd_pkg::HEX_SE);
        push_lookup(255, 255);
        push_random(150);
        wait_drained();

        configure_grid(gnd_pkg::MODE_HEX, 256);
        set_traffic(62, 0);
        push_random(200);
        wait_drained();

        // Single node grid: node zero is its own neighbour
        configure_grid(gnd_pkg::MODE_SQUARE, 1);
        set_traffic(0, 62);
        push_lookup(0, gnd_pkg::SQ_E);
        push_lookup(1, gnd_pkg::SQ_N);
        push_random(40);
        wait_drained();

        configure_grid(gnd_pkg::MODE_HEX, 1);
        set_traffic(10, 10);
        push_random(30);
        wait_drained();

        // Empty grid flags every node
        configure_grid(gnd_pkg::MODE_SQUARE, 0);
        push_lookup(0, gnd_pkg::SQ_N);
        push_random(30);
        wait_drained();

        configure_grid(gnd_pkg::MODE_HEX, 2);
        push_random(150);
        wait_drained();

        // Edge beyond the maximum saturates
        configure_grid(gnd_pkg::MODE_SQUARE, 511);
        set_traffic(0, 62);
        push_lookup(65535, 200);
        push_random(150);
        wait_drained();

        configure_grid(gnd_pkg::MODE_HEX, 257);
        set_traffic(62, 0);
        push_random(100);
        wait_drained();

        configure_grid(gnd_pkg::MODE_SQUARE, 3);
        push_random(150);
        wait_drained();

        configure_grid(gnd_pkg::MODE_HEX, 5);
        set_traffic(0, 62);
        push_random(150);
        wait_drained();

        // Back-pressure: hold the output off while the input keeps offering
        configure_grid(gnd_pkg::MODE_SQUARE, 16);
        set_traffic(0, 0);
        fork
            begin
                @(posedge i_clk);
                ready_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                ready_hold <= 1'b0;
            end
        join_none
        push_random(150);
        wait_drained();

        configure_grid(gnd_pkg::MODE_HEX, 7);
        set_traffic(10, 10);
        push_random(100);
        wait_drained();

        configure_grid(gnd_pkg::MODE_SQUARE, 256);
        set_traffic(0, 0);
        push_random(75);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/gnd_pkg.sv
hw/rtl/gnd_divider.sv
hw/rtl/grid_neighbour_from_direction_unit.sv
hw/rtl/gnd_checker.sv
bench/grid_neighbour_from_direction_unit_tb.sv
